>>> rtl/sdsi_pkg.sv
// Package: phase codes, card type codes and frame byte table for the SD SPI init sequencer.
package sdsi_pkg;

    typedef enum logic [15:0] {
        PH_IDLE       = 16'h0001,
        PH_DUMMY      = 16'h0002,
        PH_CMD0       = 16'h0004,
        PH_CMD8       = 16'h0008,
        PH_R7         = 16'h0010,
        PH_EXTRA      = 16'h0020,
        PH_V2_CMD55   = 16'h0040,
        PH_V2_ACMD41  = 16'h0080,
        PH_CMD58      = 16'h0100,
        PH_OCR        = 16'h0200,
        PH_V1_CMD55   = 16'h0400,
        PH_V1_ACMD41  = 16'h0800,
        PH_CMD1       = 16'h1000,
        PH_CMD59      = 16'h2000,
        PH_CMD16      = 16'h4000,
        PH_DONE       = 16'h8000
    } t_phase;

    localparam logic [2:0] TYPE_V1   = 3'd0;
    localparam logic [2:0] TYPE_V2   = 3'd1;
    localparam logic [2:0] TYPE_V2HC = 3'd2;
    localparam logic [2:0] TYPE_MMC  = 3'd3;
    localparam logic [2:0] TYPE_ERR  = 3'd4;

    localparam logic [7:0] BYTE_IDLE_FILL = 8'hFF;
    localparam logic [7:0] R1_IDLE        = 8'h01;
    localparam logic [7:0] R1_READY       = 8'h00;
    localparam logic [7:0] R1_V1_ILLEGAL  = 8'h05;
    localparam logic [7:0] EXTRA_BYTE     = 8'h40;
    localparam logic [7:0] HCS_BIT_MASK   = 8'h40;
    localparam logic [15:0] TIMEOUT_RESET = 16'd500;

    // Command frame byte at a position 1..6 for a command phase
    function automatic logic [7:0] frame_byte(t_phase ph, logic [2:0] pos);
        logic [7:0] b;
        b = 8'h00;
        unique case (ph)
            PH_CMD0: begin
                unique case (pos)
                    3'd1: b = 8'h40;
                    3'd6: b = 8'h95;
                    default: b = 8'h00;
                endcase
            end
            PH_CMD8: begin
                unique case (pos)
                    3'd1: b = 8'h48;
                    3'd4: b = 8'h01;
                    3'd5: b = 8'hAA;
                    3'd6: b = 8'h87;
                    default: b = 8'h00;
                endcase
            end
            PH_V2_CMD55, PH_V2_ACMD41: begin
                unique case (pos)
                    3'd1: b = (ph == PH_V2_CMD55) ? 8'h77 : 8'h69;
                    3'd2: b = 8'h40;
                    3'd6: b = 8'hFF;
                    default: b = 8'h00;
                endcase
            end
            PH_CMD58, PH_V1_CMD55, PH_V1_ACMD41, PH_CMD1, PH_CMD59: begin
                unique case (pos)
                    3'd1: begin
                        unique case (ph)
                            PH_CMD58:     b = 8'h7A;
                            PH_V1_CMD55:  b = 8'h77;
                            PH_V1_ACMD41: b = 8'h69;
                            PH_CMD1:      b = 8'h41;
                            default:      b = 8'h7B;
                        endcase
                    end
                    3'd6: b = 8'hFF;
                    default: b = 8'h00;
                endcase
            end
            PH_CMD16: begin
                unique case (pos)
                    3'd1: b = 8'h50;
                    3'd4: b = 8'h02;
                    3'd6: b = 8'hFF;
                    default: b = 8'h00;
                endcase
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/sd_spi_init_sequencer.sv
// Top level: SD card SPI-mode start-up sequencer, one exchanged byte per word.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | input     | i_in_valid/o_in_stall| i_command, i_rx_byte
//  out     | output    | o_out_valid/i_out_stall | o_tx_byte, o_select_high, o_exchange_needed,
//          |           |                      | o_fast_clock, o_done_res, o_card_type
//  cfg     | input     | i_cfg_we             | i_cfg_data (timeout_count)
//
// The sequencer state and the next result word for each word are computed from
// the registered state in a single pass and land in the output register at acceptance.
// A new word is accepted every cycle while the output register is empty or being taken.
// Reset (synchronous, active low) clears the phase to idle and timeout_count to 500.
// An output stall holds the result word and stalls the input side once it is full.
module sd_spi_init_sequencer #(
    parameter int DUMMY_BYTES = 47
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_select_high,
    output logic        o_exchange_needed,
    output logic        o_fast_clock,
    output logic        o_done_res,
    output logic [2:0]  o_card_type
);

    sdsi_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    logic [15:0] r_poll, n_poll;
    logic [15:0] r_retry, n_retry;
    logic [7:0]  r_acmd, n_acmd;
    logic [2:0]  r_ver, n_ver;
    logic [7:0]  r_ocr, n_ocr;
    logic [15:0] r_timeout;
    logic        r_out_valid;
    logic [7:0]  r_tx;
    logic        r_sel, r_ex, r_fast, r_done;
    logic [2:0]  r_type;
    logic [7:0]  n_tx;
    logic        n_sel, n_ex, n_fast, n_done;
    logic [2:0]  n_type;
    logic        accept;

    localparam logic [15:0] DUMMY_LIMIT = 16'(DUMMY_BYTES);

    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    // Next state for one delivered word
    always_comb begin
        logic [15:0] rinc, pinc;
        logic        ok, go, timed, again, do_reply;
        logic [2:0]  npos;
        rinc = 16'h0; pinc = 16'h0; ok = 1'b0; go = 1'b0; timed = 1'b0;
        again = 1'b0; do_reply = 1'b0; npos = 3'd0;
        n_phase = r_phase; n_pos = r_pos; n_poll = r_poll; n_retry = r_retry;
        n_acmd = r_acmd; n_ver = r_ver; n_ocr = r_ocr;
        pinc = r_poll + 16'd1;
        if (!i_command) begin
            n_phase = sdsi_pkg::PH_DUMMY; n_pos = 3'd0; n_poll = 16'd0; n_retry = 16'd0;
            n_acmd = 8'hFF; n_ver = sdsi_pkg::TYPE_V1; n_ocr = 8'h00;
        end else begin
            unique case (r_phase)
                sdsi_pkg::PH_IDLE, sdsi_pkg::PH_DONE: begin
                end
                sdsi_pkg::PH_DUMMY: begin
                    n_poll = pinc;
                    if (pinc >= DUMMY_LIMIT) begin
                        n_retry = 16'd0; n_phase = sdsi_pkg::PH_CMD0;
                        n_pos = 3'd0; n_poll = 16'd0;
                    end
                end
                sdsi_pkg::PH_R7, sdsi_pkg::PH_OCR, sdsi_pkg::PH_EXTRA: begin
                    npos = r_pos + 3'd1;
                    n_pos = npos;
                    if (r_phase == sdsi_pkg::PH_OCR && r_pos == 3'd0) n_ocr = i_rx_byte;
                    if (r_phase == sdsi_pkg::PH_EXTRA) begin
                        n_retry = 16'd0; n_phase = sdsi_pkg::PH_V2_CMD55;
                        n_pos = 3'd0; n_poll = 16'd0;
                    end else if (npos >= 3'd4) begin
                        if (r_phase == sdsi_pkg::PH_R7) begin
                            n_phase = sdsi_pkg::PH_EXTRA; n_pos = 3'd0; n_poll = 16'd0;
                        end else begin
                            n_phase = sdsi_pkg::PH_DONE;
                            n_ver = ((r_pos == 3'd0 ? i_rx_byte : r_ocr)
                                     & sdsi_pkg::HCS_BIT_MASK) != 8'h00
                                    ? sdsi_pkg::TYPE_V2HC : sdsi_pkg::TYPE_V2;
                        end
                    end
                end
                default: begin
                    if (r_pos < 3'd7) begin
                        n_pos = r_pos + 3'd1;
                    end else begin
                        if (i_rx_byte == 8'hFF) begin
                            n_poll = pinc;
                            again = pinc < r_timeout;
                        end
                        do_reply = ~again;
                    end
                end
            endcase
        end

        // Reply handling: loop verdict uses the raised retry count on failure
        if (do_reply) begin
            unique case (r_phase)
                sdsi_pkg::PH_V1_CMD55:  ok = (r_acmd == sdsi_pkg::R1_READY);
                sdsi_pkg::PH_V1_ACMD41, sdsi_pkg::PH_V2_ACMD41, sdsi_pkg::PH_CMD1:
                    ok = (i_rx_byte == sdsi_pkg::R1_READY);
                default: ok = (i_rx_byte == sdsi_pkg::R1_IDLE);
            endcase
            rinc  = ok ? r_retry : r_retry + 16'd1;
            go    = ~ok & (rinc < r_timeout);
            timed = (rinc == r_timeout);
            n_pos = 3'd0; n_poll = 16'd0;
            unique case (r_phase)
                sdsi_pkg::PH_CMD0: begin
                    if (go) begin
                        n_retry = rinc;
                    end else begin
                        n_retry = 16'd0; n_phase = sdsi_pkg::PH_CMD8;
                    end
                end
                sdsi_pkg::PH_CMD8: begin
                    if (i_rx_byte == sdsi_pkg::R1_IDLE) begin
                        n_phase = sdsi_pkg::PH_R7;
                    end else if (i_rx_byte == sdsi_pkg::R1_V1_ILLEGAL) begin
                        n_retry = 16'd0; n_acmd = 8'hFF; n_phase = sdsi_pkg::PH_V1_CMD55;
                    end else begin
                        n_pos = r_pos; n_poll = pinc;
                        n_ver = sdsi_pkg::TYPE_ERR; n_phase = sdsi_pkg::PH_DONE;
                    end
                end
                sdsi_pkg::PH_V2_CMD55: n_phase = sdsi_pkg::PH_V2_ACMD41;
                sdsi_pkg::PH_V2_ACMD41: begin
                    n_acmd = i_rx_byte; n_retry = rinc;
                    if (go) n_phase = sdsi_pkg::PH_V2_CMD55;
                    else if (timed) begin
                        n_ver = sdsi_pkg::TYPE_ERR; n_phase = sdsi_pkg::PH_DONE;
                    end else n_phase = sdsi_pkg::PH_CMD58;
                end
                sdsi_pkg::PH_CMD58: begin
                    if (i_rx_byte != sdsi_pkg::R1_READY) begin
                        n_ver = sdsi_pkg::TYPE_ERR; n_phase = sdsi_pkg::PH_DONE;
                    end else n_phase = sdsi_pkg::PH_OCR;
                end
                sdsi_pkg::PH_V1_CMD55, sdsi_pkg::PH_V1_ACMD41: begin
                    if (r_phase == sdsi_pkg::PH_V1_CMD55 && i_rx_byte == sdsi_pkg::R1_IDLE) begin
                        n_phase = sdsi_pkg::PH_V1_ACMD41;
                    end else begin
                        if (r_phase == sdsi_pkg::PH_V1_ACMD41) n_acmd = i_rx_byte;
                        n_retry = rinc;
                        if (go) n_phase = sdsi_pkg::PH_V1_CMD55;
                        else if (timed) begin
                            n_retry = 16'd0; n_phase = sdsi_pkg::PH_CMD1;
                        end else begin
                            n_ver = sdsi_pkg::TYPE_V1; n_phase = sdsi_pkg::PH_DONE;
                        end
                    end
                end
                sdsi_pkg::PH_CMD1: begin
                    n_retry = rinc;
                    if (go) n_phase = sdsi_pkg::PH_CMD1;
                    else if (timed) begin
                        n_ver = sdsi_pkg::TYPE_ERR; n_phase = sdsi_pkg::PH_DONE;
                    end else n_phase = sdsi_pkg::PH_CMD59;
                end
                sdsi_pkg::PH_CMD59: n_phase = sdsi_pkg::PH_CMD16;
                default: begin
                    n_ver = sdsi_pkg::TYPE_MMC; n_phase = sdsi_pkg::PH_DONE;
                end
            endcase
            // finish keeps position and poll count as they were after the poll step
            if (n_phase == sdsi_pkg::PH_DONE) begin
                n_pos = r_pos;
                n_poll = (i_rx_byte == 8'hFF) ? pinc : r_poll;
            end
        end
    end

    // Result word from the next state
    always_comb begin
        n_tx = 8'hFF; n_sel = 1'b1; n_ex = 1'b1; n_fast = 1'b0; n_done = 1'b0;
        n_type = sdsi_pkg::TYPE_V1;
        unique case (n_phase)
            sdsi_pkg::PH_IDLE: n_ex = 1'b0;
            sdsi_pkg::PH_DONE: begin
                n_ex = 1'b0; n_fast = 1'b1; n_done = 1'b1; n_type = n_ver;
            end
            sdsi_pkg::PH_DUMMY: n_tx = sdsi_pkg::BYTE_IDLE_FILL;
            sdsi_pkg::PH_R7, sdsi_pkg::PH_OCR: begin
                n_tx = 8'h00; n_sel = 1'b0;
            end
            sdsi_pkg::PH_EXTRA: begin
                n_tx = sdsi_pkg::EXTRA_BYTE; n_sel = 1'b0;
            end
            default: begin
                if (n_pos == 3'd0) begin
                    n_tx = 8'hFF;
                end else if (n_pos <= 3'd6) begin
                    n_tx = sdsi_pkg::frame_byte(n_phase, n_pos); n_sel = 1'b0;
                end else begin
                    n_tx = 8'hFF; n_sel = 1'b0;
                end
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sdsi_pkg::PH_IDLE;
            r_pos <= 3'd0; r_poll <= 16'd0; r_retry <= 16'd0;
            r_acmd <= 8'hFF; r_ver <= sdsi_pkg::TYPE_V1; r_ocr <= 8'h00;
            r_timeout <= sdsi_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (accept) begin
                r_phase <= n_phase; r_pos <= n_pos; r_poll <= n_poll;
                r_retry <= n_retry; r_acmd <= n_acmd; r_ver <= n_ver; r_ocr <= n_ocr;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tx <= n_tx; r_sel <= n_sel; r_ex <= n_ex; r_fast <= n_fast;
            r_done <= n_done; r_type <= n_type;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_tx_byte         = r_tx;
    assign o_select_high     = r_sel;
    assign o_exchange_needed = r_ex;
    assign o_fast_clock      = r_fast;
    assign o_done_res        = r_done;
    assign o_card_type       = r_type;

endmodule

>>> verif/sd_spi_init_sequencer_test.sv
// Testbench for the SD SPI init sequencer: card-like stimulus, scoreboard prediction, checks.
`timescale 1ns / 100ps

module sd_spi_init_sequencer_test;

    localparam int DUMMY_COUNT = 47;
    localparam int CYCLE_LIMIT = 600000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [7:0] tx;
        logic       sel;
        logic       ex;
        logic       fast;
        logic       done;
        logic [2:0] ctype;
    } t_word;

    typedef enum int {LOOP_GO, LOOP_STOP, LOOP_TIMED} t_loop;

    // Scoreboard: shadow sequencer state and queue of expected result words
    class init_scoreboard;
        sdsi_pkg::t_phase phase;
        int unsigned pos;
        logic [15:0] poll;
        logic [15:0] retry;
        logic [7:0] last41;
        logic [2:0] version;
        logic [7:0] ocr_top;
        logic [15:0] timeout;
        t_word      pending[$];
        int         errors;

        function new();
            timeout = sdsi_pkg::TIMEOUT_RESET;
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase = sdsi_pkg::PH_IDLE;
            pos = 0;
            poll = 16'd0;
            retry = 16'd0;
            last41 = 8'hFF;
            version = sdsi_pkg::TYPE_V1;
            ocr_top = 8'h00;
        endfunction

        function bit is_command(sdsi_pkg::t_phase p);
            return p inside {sdsi_pkg::PH_CMD0, sdsi_pkg::PH_CMD8, sdsi_pkg::PH_V2_CMD55,
                             sdsi_pkg::PH_V2_ACMD41, sdsi_pkg::PH_CMD58,
                             sdsi_pkg::PH_V1_CMD55, sdsi_pkg::PH_V1_ACMD41,
                             sdsi_pkg::PH_CMD1, sdsi_pkg::PH_CMD59, sdsi_pkg::PH_CMD16};
        endfunction

        function logic [7:0] frame(sdsi_pkg::t_phase p, int unsigned n);
            logic [7:0] b;
            b = 8'h00;
            case (n)
                1: case (p)
                    sdsi_pkg::PH_CMD0:                            b = 8'h40;
                    sdsi_pkg::PH_CMD8:                            b = 8'h48;
                    sdsi_pkg::PH_V2_CMD55, sdsi_pkg::PH_V1_CMD55:   b = 8'h77;
                    sdsi_pkg::PH_V2_ACMD41, sdsi_pkg::PH_V1_ACMD41: b = 8'h69;
                    sdsi_pkg::PH_CMD58:                           b = 8'h7A;
                    sdsi_pkg::PH_CMD1:                            b = 8'h41;
                    sdsi_pkg::PH_CMD59:                           b = 8'h7B;
                    default:                                      b = 8'h50;
                endcase
                2: if (p == sdsi_pkg::PH_V2_CMD55 || p == sdsi_pkg::PH_V2_ACMD41) b = 8'h40;
                4: if (p == sdsi_pkg::PH_CMD8) b = 8'h01;
                   else if (p == sdsi_pkg::PH_CMD16) b = 8'h02;
                5: if (p == sdsi_pkg::PH_CMD8) b = 8'hAA;
                6: if (p == sdsi_pkg::PH_CMD0) b = 8'h95;
                   else if (p == sdsi_pkg::PH_CMD8) b = 8'h87;
                   else b = 8'hFF;
                default: b = 8'h00;
            endcase
            return b;
        endfunction

        function void go(sdsi_pkg::t_phase p);
            phase = p;
            pos = 0;
            poll = 16'd0;
        endfunction

        function void finish_as(logic [2:0] t);
            version = t;
            phase = sdsi_pkg::PH_DONE;
        endfunction

        function t_loop loop_next(bit ok);
            if (!ok) begin
                retry = retry + 16'd1;
                if (retry < timeout) return LOOP_GO;
            end
            return (retry == timeout) ? LOOP_TIMED : LOOP_STOP;
        endfunction

        function void v1_loop();
            t_loop r;
            r = loop_next(last41 == sdsi_pkg::R1_READY);
            if (r == LOOP_GO) go(sdsi_pkg::PH_V1_CMD55);
            else if (r == LOOP_TIMED) begin
                retry = 16'd0;
                go(sdsi_pkg::PH_CMD1);
            end else finish_as(sdsi_pkg::TYPE_V1);
        endfunction

        // Advance on the reply byte that ends a command
        function void take_reply(logic [7:0] res);
            t_loop r;
            case (phase)
                sdsi_pkg::PH_CMD0: begin
                    if (loop_next(res == sdsi_pkg::R1_IDLE) == LOOP_GO) go(sdsi_pkg::PH_CMD0);
                    else begin
                        retry = 16'd0;
                        go(sdsi_pkg::PH_CMD8);
                    end
                end
                sdsi_pkg::PH_CMD8: begin
                    if (res == sdsi_pkg::R1_IDLE) go(sdsi_pkg::PH_R7);
                    else if (res == sdsi_pkg::R1_V1_ILLEGAL) begin
                        retry = 16'd0;
                        last41 = 8'hFF;
                        go(sdsi_pkg::PH_V1_CMD55);
                    end else finish_as(sdsi_pkg::TYPE_ERR);
                end
                sdsi_pkg::PH_V2_CMD55: go(sdsi_pkg::PH_V2_ACMD41);
                sdsi_pkg::PH_V2_ACMD41: begin
                    last41 = res;
                    r = loop_next(res == sdsi_pkg::R1_READY);
                    if (r == LOOP_GO) go(sdsi_pkg::PH_V2_CMD55);
                    else if (r == LOOP_TIMED) finish_as(sdsi_pkg::TYPE_ERR);
                    else go(sdsi_pkg::PH_CMD58);
                end
                sdsi_pkg::PH_CMD58:
                    if (res != sdsi_pkg::R1_READY) finish_as(sdsi_pkg::TYPE_ERR);
                    else go(sdsi_pkg::PH_OCR);
                sdsi_pkg::PH_V1_CMD55:
                    if (res == sdsi_pkg::R1_IDLE) go(sdsi_pkg::PH_V1_ACMD41);
                    else v1_loop();
                sdsi_pkg::PH_V1_ACMD41: begin
                    last41 = res;
                    v1_loop();
                end
                sdsi_pkg::PH_CMD1: begin
                    r = loop_next(res == sdsi_pkg::R1_READY);
                    if (r == LOOP_GO) go(sdsi_pkg::PH_CMD1);
                    else if (r == LOOP_TIMED) finish_as(sdsi_pkg::TYPE_ERR);
                    else go(sdsi_pkg::PH_CMD59);
                end
                sdsi_pkg::PH_CMD59: go(sdsi_pkg::PH_CMD16);
                sdsi_pkg::PH_CMD16: finish_as(sdsi_pkg::TYPE_MMC);
                default: ;
            endcase
        endfunction

        function t_word result_word();
            t_word w;
            w = '{tx: 8'hFF, sel: 1'b1, ex: 1'b1, fast: 1'b0, done: 1'b0,
                  ctype: sdsi_pkg::TYPE_V1};
            if (phase == sdsi_pkg::PH_IDLE) w.ex = 1'b0;
            else if (phase == sdsi_pkg::PH_DONE) begin
                w.ex = 1'b0;
                w.fast = 1'b1;
                w.done = 1'b1;
                w.ctype = version;
            end else if (phase == sdsi_pkg::PH_DUMMY) w.tx = 8'hFF;
            else if (phase == sdsi_pkg::PH_R7 || phase == sdsi_pkg::PH_OCR) begin
                w.tx = 8'h00;
                w.sel = 1'b0;
            end else if (phase == sdsi_pkg::PH_EXTRA) begin
                w.tx = sdsi_pkg::EXTRA_BYTE;
                w.sel = 1'b0;
            end else if (pos == 0) w.tx = 8'hFF;
            else if (pos <= 6) begin
                w.tx = frame(phase, pos);
                w.sel = 1'b0;
            end else w.sel = 1'b0;
            return w;
        endfunction

        // Note an accepted input word and queue the word it produces
        function void note_input(logic cmd, logic [7:0] rx);
            bit again;
            if (!cmd) begin
                clear_state();
                go(sdsi_pkg::PH_DUMMY);
            end else if (phase == sdsi_pkg::PH_IDLE || phase == sdsi_pkg::PH_DONE) begin
            end else if (phase == sdsi_pkg::PH_DUMMY) begin
                poll = poll + 16'd1;
                if (poll >= DUMMY_COUNT) begin
                    retry = 16'd0;
                    go(sdsi_pkg::PH_CMD0);
                end
            end else if (phase == sdsi_pkg::PH_R7 || phase == sdsi_pkg::PH_OCR ||
                         phase == sdsi_pkg::PH_EXTRA) begin
                if (phase == sdsi_pkg::PH_OCR && pos == 0) ocr_top = rx;
                pos++;
                if (phase == sdsi_pkg::PH_EXTRA) begin
                    retry = 16'd0;
                    go(sdsi_pkg::PH_V2_CMD55);
                end else if (pos >= 4) begin
                    if (phase == sdsi_pkg::PH_R7) go(sdsi_pkg::PH_EXTRA);
                    else finish_as((ocr_top & sdsi_pkg::HCS_BIT_MASK) != 8'h00
                                   ? sdsi_pkg::TYPE_V2HC : sdsi_pkg::TYPE_V2);
                end
            end else if (is_command(phase)) begin
                if (pos < 7) pos++;
                else begin
                    again = 0;
                    if (rx == 8'hFF) begin
                        poll = poll + 16'd1;
                        again = poll < timeout;
                    end
                    if (!again) take_reply(rx);
                end
            end
            pending.push_back(result_word());
        endfunction

        // Check one result word against the oldest expectation
        function void check_result(t_word got);
            t_word e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result word %h", $realtime, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tx !== e.tx)
                $display("%0t: tx_byte expected %h actual %h", $realtime, e.tx, got.tx);
            if (got.sel !== e.sel)
                $display("%0t: select_high expected %b actual %b", $realtime, e.sel, got.sel);
            if (got.ex !== e.ex)
                $display("%0t: exchange_needed expected %b actual %b", $realtime, e.ex, got.ex);
            if (got.fast !== e.fast)
                $display("%0t: fast_clock expected %b actual %b", $realtime, e.fast, got.fast);
            if (got.done !== e.done)
                $display("%0t: done_res expected %b actual %b", $realtime, e.done, got.done);
            if (got.ctype !== e.ctype)
                $display("%0t: card_type expected %0d actual %0d", $realtime, e.ctype, got.ctype);
            if (got !== e) errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_command = 1'b1;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_tx_byte;
    logic        o_select_high;
    logic        o_exchange_needed;
    logic        o_fast_clock;
    logic        o_done_res;
    logic [2:0]  o_card_type;

    init_scoreboard sb = new();
    bit no_idle = 0;
    bit long_hold_go = 0;
    int cycles = 0;

    sd_spi_init_sequencer #(.DUMMY_BYTES(DUMMY_COUNT)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_tx_byte(o_tx_byte), .o_select_high(o_select_high),
        .o_exchange_needed(o_exchange_needed), .o_fast_clock(o_fast_clock),
        .o_done_res(o_done_res), .o_card_type(o_card_type)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("sd_spi_init_sequencer_test failed");
            $finish;
        end
    end

    // Check every accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result('{o_tx_byte, o_select_high, o_exchange_needed,
                              o_fast_clock, o_done_res, o_card_type});
    end

    // Stall the output in bursts, plus one long hold-off
    initial begin
        bit taken;
        taken = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_go && !taken) begin
                taken = 1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 8) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(logic cmd, logic [7:0] rx);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(cmd, rx);
    endtask

    // Pick a card reply for the command now polling
    function automatic logic [7:0] card_reply();
        int unsigned r;
        r = $urandom_range(0, 99);
        case (sb.phase)
            sdsi_pkg::PH_CMD0:  return sdsi_pkg::R1_IDLE;
            sdsi_pkg::PH_CMD8:
                return (r < 55) ? sdsi_pkg::R1_IDLE :
                       (r < 90) ? sdsi_pkg::R1_V1_ILLEGAL : 8'($urandom);
            sdsi_pkg::PH_V2_ACMD41, sdsi_pkg::PH_V1_ACMD41, sdsi_pkg::PH_CMD1:
                return (r < 40) ? sdsi_pkg::R1_READY : sdsi_pkg::R1_IDLE;
            sdsi_pkg::PH_CMD58: return (r < 90) ? sdsi_pkg::R1_READY : 8'($urandom);
            sdsi_pkg::PH_V1_CMD55: return (r < 80) ? sdsi_pkg::R1_IDLE : sdsi_pkg::R1_READY;
            default:  return 8'($urandom);
        endcase
    endfunction

    // Act as a card: mostly well-formed replies, some polls, noise and restarts
    task automatic run_card(int count);
        int unsigned r;
        logic [7:0] rx;
        repeat (count) begin
            r = $urandom_range(0, 99);
            rx = 8'($urandom);
            if (sb.phase == sdsi_pkg::PH_IDLE || (sb.phase == sdsi_pkg::PH_DONE && r < 30) ||
                r == 0)
                send_word(1'b0, rx);
            else begin
                if (sb.is_command(sb.phase) && sb.pos == 7) begin
                    if (r < 20) rx = 8'hFF;
                    else if (r < 90) rx = card_reply();
                end
                send_word(1'b1, rx);
            end
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Wait until every expected word has arrived, then let the block settle
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.timeout = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] settings[5];
        settings = '{16'd1, 16'd2, 16'd65535, 16'd3, 16'd0};
        settings[4] = 16'($urandom_range(1, 12));
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: deliveries while idle, start, early restart, then a default run
        send_word(1'b1, 8'h00);
        send_word(1'b1, 8'hFF);
        send_word(1'b0, 8'hA5);
        repeat (5) send_word(1'b1, 8'h5A);
        send_word(1'b0, 8'h00);
        run_card(230);
        drain();

        foreach (settings[k]) begin
            set_timeout(settings[k]);
            if (k == 0) long_hold_go = 1;
            if (k == 4) no_idle = 1;
            run_card(240);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("sd_spi_init_sequencer_test passed");
        else
            $display("sd_spi_init_sequencer_test failed");
        $finish;
    end
endmodule
